>>> rtl/core/vspc_pkg.sv
// ----------------------------------------------------------------------------
// Version string parse/compare package
// Shared widths, character codes, verdict codes, register indexes and the
// structures passed between the parser and the top level.
// ----------------------------------------------------------------------------
package vspc_pkg;

    // Field widths
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned COMP_W    = 20;
    localparam int unsigned VERDICT_W = 2;
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned CFG_W     = 20;

    // Packed result: verdict, has_extra, then three components
    localparam int unsigned RESULT_W   = VERDICT_W + 1 + 3 * COMP_W;
    localparam int unsigned OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int unsigned IN_DATA_W  = ((CHAR_W + 7) / 8) * 8;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_V = 8'h56;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_V = 8'h76;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_NEWER      = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NOT_NEWER  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_UNREADABLE = 2'd2;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_RUNNING_MAJOR = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RUNNING_MINOR = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RUNNING_PATCH = 2'd2;

    // Component slot indexes
    localparam logic [1:0] SLOT_MAJOR = 2'd0;
    localparam logic [1:0] SLOT_MINOR = 2'd1;
    localparam logic [1:0] SLOT_PATCH = 2'd2;

    // Parser phases
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_COMP   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    // A version triple
    typedef struct packed {
        logic [COMP_W-1:0] major;
        logic [COMP_W-1:0] minor;
        logic [COMP_W-1:0] patch;
    } version_t;

    // Outcome of one parser step
    typedef struct packed {
        logic                 emit;
        logic [VERDICT_W-1:0] verdict;
        logic                 has_extra;
        version_t             offered;
    } step_result_t;

endpackage

>>> rtl/core/version_string_parse_compare.sv
// ----------------------------------------------------------------------------
// Version string parse and compare
// Parses a zero-terminated version string and compares it to the running
// version held in three configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one byte of the offered string per transaction
//   in s_tdata. A zero byte ends the string; it alone produces an output
//   transaction holding the verdict and the parsed components.
//   The running version is loaded through wr_en / wr_index / wr_data while the
//   block is idle; index 0 is major, 1 minor, 2 patch, 3 is ignored.
//   A terminating byte passes through the input register and then the result
//   register before it is presented on m_tvalid. Throughput: one byte per cycle,
//   sustained, as long as the output side keeps taking results; the input
//   register feeds the parser and the result register in a single step.
//   When the receiver stalls, the held result stays in the output register
//   and non-terminating bytes keep flowing; a zero byte waits in the input
//   register until the output register frees up.
//   Reset clears the parse state, the running version and the valid flags of both registers.
// ----------------------------------------------------------------------------
module version_string_parse_compare #(
    parameter int unsigned COMPONENT_LIMIT = 99999
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [vspc_pkg::IN_DATA_W-1:0]       s_tdata,   // [7:0] char_code
    // Output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] verdict, [2] has_extra, [22:3] offered_major,
    // [42:23] offered_minor, [62:43] offered_patch, [63] zero
    output logic [vspc_pkg::OUT_DATA_W-1:0]      m_tdata,
    // Configuration write port
    input  logic                                 wr_en,
    input  logic [vspc_pkg::REG_IDX_W-1:0]       wr_index,
    input  logic [vspc_pkg::CFG_W-1:0]           wr_data
);

    logic                               in_valid_reg;
    logic [vspc_pkg::CHAR_W-1:0]        in_char_reg;
    logic                               out_valid_reg;
    logic [vspc_pkg::RESULT_W-1:0]      out_data_reg;
    vspc_pkg::version_t                 running_reg;
    vspc_pkg::step_result_t             step_res;
    logic                               out_free;
    logic                               fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                vspc_pkg::REG_RUNNING_MAJOR: running_reg.major <= wr_data;
                vspc_pkg::REG_RUNNING_MINOR: running_reg.minor <= wr_data;
                vspc_pkg::REG_RUNNING_PATCH: running_reg.patch <= wr_data;
                default: ;
            endcase
        end
    end

    // Handshake control: only a terminating byte needs room at the output
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && ((in_char_reg != vspc_pkg::CHAR_NUL) || out_free);
    assign s_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata[vspc_pkg::CHAR_W-1:0];
        end
    end

    // Parser and comparator
    vspc_parser #(
        .COMPONENT_LIMIT (COMPONENT_LIMIT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .char_code (in_char_reg),
        .running   (running_reg),
        .result    (step_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && step_res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && step_res.emit)
        begin
            out_data_reg <= {step_res.offered.patch, step_res.offered.minor,
                             step_res.offered.major, step_res.has_extra, step_res.verdict};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = vspc_pkg::OUT_DATA_W'(out_data_reg);

    // Every terminating byte taken by the parser produces exactly one result.
    a_nul_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (step_res.emit == (in_char_reg == vspc_pkg::CHAR_NUL)))
        else $error("terminating byte and result emission disagree");

    // An unreadable verdict carries no components and no trailing-text flag.
    a_unreadable_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == vspc_pkg::VERDICT_UNREADABLE))
        |-> (m_tdata[vspc_pkg::OUT_DATA_W-1:2] == '0))
        else $error("unreadable result carries parsed data");

    // A new result only appears after a parser step on a terminating byte.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(fire && (in_char_reg == vspc_pkg::CHAR_NUL)))
        else $error("result appeared without a terminating byte");

    // The verdict is always one of the three defined codes.
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[1:0] == vspc_pkg::VERDICT_NEWER)
                   || (m_tdata[1:0] == vspc_pkg::VERDICT_NOT_NEWER)
                   || (m_tdata[1:0] == vspc_pkg::VERDICT_UNREADABLE)))
        else $error("undefined verdict code");

endmodule

>>> rtl/core/vspc_parser.sv
// ----------------------------------------------------------------------------
// Version string parser
// Holds the parse state, advances it by one byte per step and, on the
// terminating zero byte, forms the verdict against the running version.
// ----------------------------------------------------------------------------
module vspc_parser #(
    parameter int unsigned COMPONENT_LIMIT = 99999
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [vspc_pkg::CHAR_W-1:0]    char_code,
    input  vspc_pkg::version_t             running,
    output vspc_pkg::step_result_t         result
);

    localparam logic [vspc_pkg::COMP_W-1:0] LIMIT = vspc_pkg::COMP_W'(COMPONENT_LIMIT);

    vspc_pkg::phase_t              phase_reg, phase_next;
    logic [1:0]                    idx_reg, idx_next;
    logic [vspc_pkg::COMP_W-1:0]   acc_reg, acc_next;
    logic [vspc_pkg::COMP_W-1:0]   comp_reg  [3];
    logic [vspc_pkg::COMP_W-1:0]   comp_next [3];

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= vspc_pkg::PH_START;
            idx_reg   <= vspc_pkg::SLOT_MAJOR;
            acc_reg   <= '0;
            for (int k = 0; k < 3; k++)
            begin
                comp_reg[k] <= '0;
            end
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            for (int k = 0; k < 3; k++)
            begin
                comp_reg[k] <= comp_next[k];
            end
        end
    end

    // Next state, emitted result and comparison against the running version
    always_comb
    begin
        logic                        is_digit;
        logic [vspc_pkg::COMP_W-1:0] digit;
        logic [vspc_pkg::COMP_W-1:0] acc_scaled;
        logic                        go_error;
        logic                        emit_ok;
        logic                        extra;
        logic                        newer;
        vspc_pkg::version_t          offered;

        is_digit   = (char_code >= vspc_pkg::CHAR_ZERO) && (char_code <= vspc_pkg::CHAR_NINE);
        digit      = vspc_pkg::COMP_W'(char_code[3:0]);
        acc_scaled = {acc_reg[vspc_pkg::COMP_W-4:0], 3'b000}
                   + {acc_reg[vspc_pkg::COMP_W-2:0], 1'b0} + digit;

        phase_next = phase_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        for (int k = 0; k < 3; k++)
        begin
            comp_next[k] = comp_reg[k];
        end
        go_error = 1'b0;
        emit_ok  = 1'b0;
        extra    = 1'b0;

        unique case (phase_reg)
            vspc_pkg::PH_START:
            begin
                if ((char_code == vspc_pkg::CHAR_LOWER_V) || (char_code == vspc_pkg::CHAR_UPPER_V))
                begin
                    phase_next = vspc_pkg::PH_COMP;
                end
                else if (is_digit)
                begin
                    acc_next   = digit;
                    phase_next = vspc_pkg::PH_DIGITS;
                end
                else
                begin
                    go_error = 1'b1;
                end
            end
            vspc_pkg::PH_COMP:
            begin
                if (is_digit)
                begin
                    acc_next   = digit;
                    phase_next = vspc_pkg::PH_DIGITS;
                end
                else
                begin
                    go_error = 1'b1;
                end
            end
            vspc_pkg::PH_DIGITS:
            begin
                if (is_digit)
                begin
                    // Refuse a further digit once the component is already too long
                    if (acc_reg > LIMIT)
                    begin
                        go_error = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_scaled;
                    end
                end
                else if (idx_reg == vspc_pkg::SLOT_PATCH)
                begin
                    comp_next[2] = acc_reg;
                    acc_next     = '0;
                    if (char_code == vspc_pkg::CHAR_NUL)
                    begin
                        emit_ok = 1'b1;
                    end
                    else
                    begin
                        phase_next = vspc_pkg::PH_TRAIL;
                    end
                end
                else if ((idx_reg == vspc_pkg::SLOT_MAJOR) || (idx_reg == vspc_pkg::SLOT_MINOR))
                begin
                    comp_next[idx_reg] = acc_reg;
                    acc_next           = '0;
                    if (char_code == vspc_pkg::CHAR_DOT)
                    begin
                        idx_next   = idx_reg + 2'd1;
                        phase_next = vspc_pkg::PH_COMP;
                    end
                    else
                    begin
                        go_error = 1'b1;
                    end
                end
                else
                begin
                    go_error = 1'b1;
                end
            end
            vspc_pkg::PH_TRAIL:
            begin
                if (char_code == vspc_pkg::CHAR_NUL)
                begin
                    emit_ok = 1'b1;
                    extra   = 1'b1;
                end
            end
            default:
            begin
                go_error = 1'b1;
            end
        endcase

        if (go_error && (char_code != vspc_pkg::CHAR_NUL))
        begin
            phase_next = vspc_pkg::PH_ERROR;
        end

        // The zero byte always closes the string and clears the parse state
        if (char_code == vspc_pkg::CHAR_NUL)
        begin
            phase_next = vspc_pkg::PH_START;
            idx_next   = vspc_pkg::SLOT_MAJOR;
            acc_next   = '0;
            for (int k = 0; k < 3; k++)
            begin
                comp_next[k] = '0;
            end
        end

        // The patch component is still in the accumulator when the zero byte
        // directly follows its last digit.
        offered.major = comp_reg[0];
        offered.minor = comp_reg[1];
        offered.patch = (phase_reg == vspc_pkg::PH_DIGITS) ? acc_reg : comp_reg[2];

        newer = (offered.major > running.major)
             || ((offered.major == running.major)
                 && ((offered.minor > running.minor)
                     || ((offered.minor == running.minor)
                         && (offered.patch > running.patch))));

        result.emit = (char_code == vspc_pkg::CHAR_NUL);
        if (emit_ok)
        begin
            result.verdict   = newer ? vspc_pkg::VERDICT_NEWER : vspc_pkg::VERDICT_NOT_NEWER;
            result.has_extra = extra;
            result.offered   = offered;
        end
        else
        begin
            result.verdict   = vspc_pkg::VERDICT_UNREADABLE;
            result.has_extra = 1'b0;
            result.offered   = '0;
        end
    end

endmodule

>>> tb/sv/vspc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Version string parse/compare checker
// Watches the byte stream, the result stream and the register write port.
// Keeps its own parser and copy of the running version, queues the result
// that each terminating byte should produce, and compares every result
// transaction field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module vspc_checker #(
    parameter int unsigned COMPONENT_LIMIT = 99999
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [vspc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [vspc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               wr_en,
    input  logic [vspc_pkg::REG_IDX_W-1:0]     wr_index,
    input  logic [vspc_pkg::CFG_W-1:0]         wr_data,
    output int unsigned                        outstanding,
    output int unsigned                        fail_count
);

    // Bit positions of the result fields in m_tdata
    localparam int unsigned EXTRA_POS = vspc_pkg::VERDICT_W;
    localparam int unsigned MAJOR_POS = vspc_pkg::VERDICT_W + 1;
    localparam int unsigned MINOR_POS = MAJOR_POS + vspc_pkg::COMP_W;
    localparam int unsigned PATCH_POS = MINOR_POS + vspc_pkg::COMP_W;

    typedef struct packed {
        logic [vspc_pkg::VERDICT_W-1:0] verdict;
        logic                           has_extra;
        vspc_pkg::version_t             offered;
    } version_verdict_t;

    // Parser state and running version
    vspc_pkg::phase_t            phase;
    logic [1:0]                  slot;
    logic [vspc_pkg::COMP_W-1:0] acc;
    logic [vspc_pkg::COMP_W-1:0] comps [0:2];
    vspc_pkg::version_t          running;

    version_verdict_t  expected_verdicts [$];

    // Queue the result of a finished string and start over.
    task automatic close_string(input logic ok, input logic extra);
        version_verdict_t   rec;
        vspc_pkg::version_t offered;
        offered.major = comps[vspc_pkg::SLOT_MAJOR];
        offered.minor = comps[vspc_pkg::SLOT_MINOR];
        offered.patch = comps[vspc_pkg::SLOT_PATCH];
        if (!ok)
        begin
            rec.verdict   = vspc_pkg::VERDICT_UNREADABLE;
            rec.has_extra = 1'b0;
            rec.offered   = '0;
        end
        else
        begin
            // Packed triple compares major first, then minor, then patch.
            rec.verdict   = (offered > running) ? vspc_pkg::VERDICT_NEWER
                                                : vspc_pkg::VERDICT_NOT_NEWER;
            rec.has_extra = extra;
            rec.offered   = offered;
        end
        expected_verdicts.push_back(rec);
        phase                       = vspc_pkg::PH_START;
        slot                        = vspc_pkg::SLOT_MAJOR;
        acc                         = '0;
        comps[vspc_pkg::SLOT_MAJOR] = '0;
        comps[vspc_pkg::SLOT_MINOR] = '0;
        comps[vspc_pkg::SLOT_PATCH] = '0;
    endtask

    // Advance the parser by one accepted byte.
    task automatic parse_char(input logic [vspc_pkg::CHAR_W-1:0] c);
        logic is_num;
        logic fail_now;
        is_num   = (c >= vspc_pkg::CHAR_ZERO) && (c <= vspc_pkg::CHAR_NINE);
        fail_now = 1'b0;
        case (phase) inside
            vspc_pkg::PH_START, vspc_pkg::PH_COMP:
            begin
                if (phase == vspc_pkg::PH_START
                    && (c == vspc_pkg::CHAR_LOWER_V || c == vspc_pkg::CHAR_UPPER_V))
                    phase = vspc_pkg::PH_COMP;
                else if (is_num)
                begin
                    acc   = vspc_pkg::COMP_W'(c - vspc_pkg::CHAR_ZERO);
                    phase = vspc_pkg::PH_DIGITS;
                end
                else
                    fail_now = 1'b1;
            end
            vspc_pkg::PH_DIGITS:
            begin
                if (is_num)
                begin
                    // A digit is refused once the value is already past the limit.
                    if (acc > COMPONENT_LIMIT)
                        fail_now = 1'b1;
                    else
                        acc = vspc_pkg::COMP_W'(acc * 10 + (c - vspc_pkg::CHAR_ZERO));
                end
                else
                begin
                    comps[slot] = acc;
                    acc         = '0;
                    if (slot != vspc_pkg::SLOT_PATCH)
                    begin
                        if (c == vspc_pkg::CHAR_DOT)
                        begin
                            slot  = slot + 2'd1;
                            phase = vspc_pkg::PH_COMP;
                        end
                        else
                            fail_now = 1'b1;
                    end
                    else if (c == vspc_pkg::CHAR_NUL)
                        close_string(1'b1, 1'b0);
                    else
                        phase = vspc_pkg::PH_TRAIL;
                end
            end
            vspc_pkg::PH_TRAIL:
            begin
                if (c == vspc_pkg::CHAR_NUL)
                    close_string(1'b1, 1'b1);
            end
            default:
                fail_now = 1'b1;
        endcase
        // Error phase: swallow bytes until the terminator.
        if (fail_now)
        begin
            if (c == vspc_pkg::CHAR_NUL)
                close_string(1'b0, 1'b0);
            else
                phase = vspc_pkg::PH_ERROR;
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input logic [vspc_pkg::OUT_DATA_W-1:0] d);
        version_verdict_t want;
        if (expected_verdicts.size() == 0)
        begin
            $error("result transaction with no string pending: %h", d);
            fail_count++;
        end
        else
        begin
            want = expected_verdicts.pop_front();
            compare_field("verdict", want.verdict, d[vspc_pkg::VERDICT_W-1:0]);
            compare_field("has_extra", want.has_extra, d[EXTRA_POS]);
            compare_field("offered_major", want.offered.major,
                          d[MAJOR_POS +: vspc_pkg::COMP_W]);
            compare_field("offered_minor", want.offered.minor,
                          d[MINOR_POS +: vspc_pkg::COMP_W]);
            compare_field("offered_patch", want.offered.patch,
                          d[PATCH_POS +: vspc_pkg::COMP_W]);
        end
    endtask

    // Register writes, byte transactions and result transactions, in that order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase                       = vspc_pkg::PH_START;
            slot                        = vspc_pkg::SLOT_MAJOR;
            acc                         = '0;
            comps[vspc_pkg::SLOT_MAJOR] = '0;
            comps[vspc_pkg::SLOT_MINOR] = '0;
            comps[vspc_pkg::SLOT_PATCH] = '0;
            running                     = '0;
            expected_verdicts.delete();
            fail_count                  = 0;
            outstanding                 = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    vspc_pkg::REG_RUNNING_MAJOR: running.major = wr_data;
                    vspc_pkg::REG_RUNNING_MINOR: running.minor = wr_data;
                    vspc_pkg::REG_RUNNING_PATCH: running.patch = wr_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata[vspc_pkg::CHAR_W-1:0]);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            outstanding = expected_verdicts.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Version string parse/compare testbench
// Feeds directed and random version strings, byte by byte, into the block
// under several running versions and several patterns of idle cycles on
// both streams. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned COMPONENT_LIMIT = 99999;
    localparam int unsigned PHASE_BYTES     = 250;
    localparam int unsigned HOLDOFF_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned MAX_COMPONENT   = 999999;

    // Index past the three registers; writes to it must have no effect.
    localparam logic [vspc_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [vspc_pkg::IN_DATA_W-1:0]    s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [vspc_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                              wr_en;
    logic [vspc_pkg::REG_IDX_W-1:0]    wr_index;
    logic [vspc_pkg::CFG_W-1:0]        wr_data;

    int unsigned outstanding;
    int unsigned fail_count;

    // Stimulus control
    int unsigned sender_pct;
    int unsigned receiver_pct;
    bit          holdoff_req;
    int unsigned sent_count;
    int unsigned quiet_cycles = 0;
    int unsigned run_cfg [0:2];
    logic [vspc_pkg::CHAR_W-1:0] text_q [$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    version_string_parse_compare #(
        .COMPONENT_LIMIT(COMPONENT_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    vspc_checker #(
        .COMPONENT_LIMIT(COMPONENT_LIMIT)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                holdoff_req = 1'b0;
            end
            m_tready <= !(receiver_pct != 0 && $urandom_range(0, 99) < receiver_pct);
        end
    end

    // Offer one byte and wait until the transaction completes.
    task automatic send_char(input logic [vspc_pkg::CHAR_W-1:0] c);
        // Each cycle before the byte is idle with the sender's idle share.
        while (sender_pct != 0 && $urandom_range(0, 99) < sender_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic send_text();
        int unsigned i;
        for (i = 0; i < text_q.size(); i++)
            send_char(text_q[i]);
        text_q.delete();
    endtask

    task automatic add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic add_num(input int unsigned n);
        add_str($sformatf("%0d", n));
    endtask

    task automatic send_version(input string s);
        add_str(s);
        text_q.push_back(vspc_pkg::CHAR_NUL);
        send_text();
    endtask

    // Wait until every result has come out and the pipeline is empty.
    task automatic drain();
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [vspc_pkg::REG_IDX_W-1:0] idx,
                             input logic [vspc_pkg::CFG_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en    <= 1'b0;
        @(negedge clk);
        if (idx != REG_UNUSED)
            run_cfg[idx] = val;
    endtask

    task automatic set_running(input logic [vspc_pkg::CFG_W-1:0] maj,
                               input logic [vspc_pkg::CFG_W-1:0] mn,
                               input logic [vspc_pkg::CFG_W-1:0] pat);
        write_reg(vspc_pkg::REG_RUNNING_MAJOR, maj);
        write_reg(vspc_pkg::REG_RUNNING_MINOR, mn);
        write_reg(vspc_pkg::REG_RUNNING_PATCH, pat);
    endtask

    // Offered components are often equal or adjacent to the running ones so
    // that the compare reaches the minor and patch fields.
    function automatic int unsigned pick_component(input int unsigned rk);
        int unsigned r;
        int unsigned v;
        r = $urandom_range(0, 9);
        v = $urandom_range(0, 20);
        if (r < 2)
            v = $urandom_range(0, MAX_COMPONENT);
        else if (rk <= MAX_COMPONENT && r < 8)
        begin
            v = rk;
            if (r == 6 && rk < MAX_COMPONENT)
                v = rk + 1;
            if (r == 7 && rk > 0)
                v = rk - 1;
        end
        return v;
    endfunction

    task automatic add_wellformed();
        int unsigned k;
        case ($urandom_range(0, 2))
            1: text_q.push_back(vspc_pkg::CHAR_LOWER_V);
            2: text_q.push_back(vspc_pkg::CHAR_UPPER_V);
            default: ;
        endcase
        for (k = 0; k < 3; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                text_q.push_back(vspc_pkg::CHAR_ZERO);
            add_num(pick_component(run_cfg[k]));
            if (k < 2)
                text_q.push_back(vspc_pkg::CHAR_DOT);
        end
    endtask

    task automatic add_noise(input int unsigned max_len);
        int unsigned n;
        n = $urandom_range(0, max_len);
        repeat (n) text_q.push_back(vspc_pkg::CHAR_W'($urandom_range(1, 255)));
    endtask

    // Mostly well-formed strings; the rest are noise, cut short, too long
    // a component, or a corrupted byte.
    task automatic make_random_string();
        int unsigned keep;
        int unsigned pos;
        text_q.delete();
        if ($urandom_range(0, 99) < 70)
        begin
            add_wellformed();
            if ($urandom_range(0, 4) == 0)
                add_noise(4);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: add_noise(6);
                1:
                begin
                    add_wellformed();
                    keep = $urandom_range(0, text_q.size() - 1);
                    while (text_q.size() > keep) void'(text_q.pop_back());
                end
                2:
                begin
                    add_num($urandom_range(1000000, 9999999));
                    add_str(".0.0");
                end
                default:
                begin
                    add_wellformed();
                    pos = $urandom_range(0, text_q.size() - 1);
                    text_q[pos] = vspc_pkg::CHAR_W'($urandom_range(1, 255));
                end
            endcase
        end
        text_q.push_back(vspc_pkg::CHAR_NUL);
    endtask

    task automatic run_phase(input logic [vspc_pkg::CFG_W-1:0] maj,
                             input logic [vspc_pkg::CFG_W-1:0] mn,
                             input logic [vspc_pkg::CFG_W-1:0] pat, input int unsigned s_pct,
                             input int unsigned r_pct, input bit with_holdoff);
        int unsigned start;
        set_running(maj, mn, pat);
        sender_pct   = s_pct;
        receiver_pct = r_pct;
        if (with_holdoff)
            holdoff_req = 1'b1;
        start = sent_count;
        while (sent_count - start < PHASE_BYTES)
        begin
            make_random_string();
            send_text();
        end
        s_tvalid <= 1'b0;
        drain();
    endtask

    // Main stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        sender_pct   = 0;
        receiver_pct = 0;
        holdoff_req  = 1'b0;
        sent_count   = 0;
        run_cfg[0]   = 0;
        run_cfg[1]   = 0;
        run_cfg[2]   = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings against the reset running version 0.0.0
        send_version("");
        send_version("0.0.0");
        send_version("v1.2.3");
        send_version("V1.2.3");
        send_version("vv1.2.3");
        send_version("x1.2.3");
        send_version("1..2");
        send_version("1.2");
        send_version("1.2.3abc");
        send_version("1.2.3.");
        send_version("999999.999999.999999");
        send_version("1000000.0.0");
        // Bytes after an error, including high-bit values
        add_str("a");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h80);
        send_version(".");
        // Trailing bytes, one with the high bit set
        add_str("1.2.3");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h01);
        send_version("");
        s_tvalid <= 1'b0;
        drain();

        // Each compare stage decides both ways against running version 1.2.3
        set_running(20'd1, 20'd2, 20'd3);
        send_version("2.0.0");
        send_version("0.9.9");
        send_version("1.3.0");
        send_version("1.1.9");
        send_version("1.2.4");
        send_version("1.2.2");
        send_version("1.2.3");
        s_tvalid <= 1'b0;
        drain();

        // Random phases with different running versions and idle patterns
        run_phase(20'd1, 20'd2, 20'd3, 0, 0, 1'b1);
        write_reg(REG_UNUSED, 20'h12345);
        run_phase(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 56, 0, 1'b0);
        run_phase(vspc_pkg::CFG_W'($urandom_range(0, MAX_COMPONENT)),
                  vspc_pkg::CFG_W'($urandom_range(0, MAX_COMPONENT)),
                  vspc_pkg::CFG_W'($urandom_range(0, MAX_COMPONENT)), 0, 56, 1'b0);
        run_phase(20'd5, 20'd0, 20'd999999, 9, 9, 1'b1);
        run_phase(20'd0, 20'd0, 20'd0, 0, 0, 1'b0);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/vspc_pkg.sv
rtl/core/vspc_parser.sv
rtl/core/version_string_parse_compare.sv
tb/sv/vspc_checker.sv
tb/sv/tb.sv
